@@ rtl/actuator_position_targeting_assert.svh @@
// assertion macros for the actuator position targeting block
// expects aclk and aresetn in the scope of each use
`ifndef ACTUATOR_POSITION_TARGETING_ASSERT_SVH
`define ACTUATOR_POSITION_TARGETING_ASSERT_SVH

// same-cycle implication, checked out of reset
`define APT_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define APT_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/apt_pkg.sv @@
// shared types and codes for the actuator position targeting block
// no dependencies
package apt_pkg;

    // default channel count
    localparam int CHANNELS_DEF = 8;

    // event kinds
    localparam logic [2:0] KIND_INIT   = 3'd0;
    localparam logic [2:0] KIND_REF    = 3'd1;
    localparam logic [2:0] KIND_LIMIT  = 3'd2;
    localparam logic [2:0] KIND_TARGET = 3'd3;
    localparam logic [2:0] KIND_IN_SW  = 3'd4;
    localparam logic [2:0] KIND_OUT_SW = 3'd5;
    localparam logic [2:0] KIND_TICK   = 3'd6;

    // move direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_OUT  = 2'd1;
    localparam logic [1:0] DIR_IN   = 2'd3;

    // motor commands
    localparam logic [1:0] CMD_STOP = 2'd0;
    localparam logic [1:0] CMD_IN   = 2'd1;
    localparam logic [1:0] CMD_OUT  = 2'd2;

    // distance when there is no target to report
    localparam logic [15:0] NO_DIST   = 16'h7FFF;
    localparam logic [15:0] LIMIT_DEF = 16'h7FFF;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         channel;
        logic signed [15:0] value;
        logic [15:0]        adc_sample;
        logic               motor_on;
    } apt_in_t;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] distance;
        logic signed [15:0] position;
        logic               is_referenced;
        logic               is_moving;
    } apt_out_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic commit;
    } apt_cmd_t;

endpackage

@@ rtl/apt_ctrl.sv @@
// handshake controller: accepts an item, runs one execute step, holds the result
// depends on apt_pkg and actuator_position_targeting_assert.svh
`include "actuator_position_targeting_assert.svh"

module apt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output apt_pkg::apt_cmd_t cmd
);
    import apt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    // output slot is free when empty or being drained this cycle
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.load   = s_valid && (state_reg == ST_IDLE);
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;
    assign m_valid    = m_valid_reg;

    // next state and result valid
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // checks
    `APT_ASSERT_NOW(a_commit_free, cmd.commit, !m_valid_reg || m_ready, "commit into busy output")
    `APT_ASSERT_NEXT(a_accept_exec, s_valid && s_ready, !s_ready, "accepted item not executed")
    `APT_ASSERT_NEXT(a_commit_valid, cmd.commit, m_valid, "committed item has no result")
    `APT_ASSERT_NOW(a_load_commit, cmd.load, !cmd.commit, "load and commit together")

endmodule

@@ rtl/apt_dp.sv @@
// datapath: item register, per-channel tracking state, event logic, result register
// depends on apt_pkg
module apt_dp #(
    parameter int CHANNELS = apt_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  apt_pkg::apt_cmd_t cmd,
    input  apt_pkg::apt_in_t  s_data,
    output apt_pkg::apt_out_t m_data
);
    import apt_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    apt_in_t  item_reg;
    apt_out_t res_reg, res_next;

    // per-channel state
    logic [15:0] pos_reg    [CHANNELS];
    logic        ref_reg    [CHANNELS];
    logic        act_reg    [CHANNELS];
    logic [15:0] ctgt_reg   [CHANNELS];
    logic [1:0]  cdir_reg   [CHANNELS];
    logic        csw_reg    [CHANNELS];
    logic [15:0] ltgt_reg   [CHANNELS];
    logic [1:0]  ldir_reg   [CHANNELS];
    logic        lsw_reg    [CHANNELS];
    logic [15:0] band_reg   [CHANNELS];
    logic [15:0] lim_reg    [CHANNELS];
    logic [15:0] pz_reg     [CHANNELS];

    logic [IDX_W-1:0] idx;
    logic             in_range;

    logic [15:0] pos_next, ctgt_next, ltgt_next, band_next, lim_next, pz_next;
    logic        ref_next, act_next, csw_next, lsw_next;
    logic [1:0]  cdir_next, ldir_next;
    logic [1:0]  command;
    logic [15:0] dist_val;
    logic [15:0] sw_tgt;
    logic signed [17:0] t_ext, win_lo, win_hi;

    assign idx      = item_reg.channel[IDX_W-1:0];
    assign in_range = ({1'b0, item_reg.channel} < 5'(CHANNELS));

    // deadband window, full precision
    assign t_ext  = 18'(item_reg.value);
    assign win_lo = 18'($signed(pos_reg[idx])) - 18'($signed(band_reg[idx]));
    assign win_hi = 18'($signed(pos_reg[idx])) + 18'($signed(band_reg[idx]));
    assign sw_tgt = (item_reg.kind == KIND_IN_SW) ? 16'd0 : lim_reg[idx];

    // event logic for the addressed channel
    always_comb begin
        pos_next  = pos_reg[idx];
        ref_next  = ref_reg[idx];
        act_next  = act_reg[idx];
        ctgt_next = ctgt_reg[idx];
        cdir_next = cdir_reg[idx];
        csw_next  = csw_reg[idx];
        ltgt_next = ltgt_reg[idx];
        ldir_next = ldir_reg[idx];
        lsw_next  = lsw_reg[idx];
        band_next = band_reg[idx];
        lim_next  = lim_reg[idx];
        pz_next   = pz_reg[idx];
        command   = CMD_STOP;
        dist_val  = NO_DIST;
        case (item_reg.kind)
            KIND_INIT: begin
                band_next = item_reg.value;
                ctgt_next = 16'd0;
                cdir_next = DIR_NONE;
                csw_next  = 1'b0;
                act_next  = 1'b0;
                ref_next  = 1'b0;
            end
            KIND_REF: begin
                pos_next = 16'd0;
                pz_next  = item_reg.adc_sample;
                ref_next = 1'b1;
            end
            KIND_LIMIT: begin
                if (ref_reg[idx]) begin
                    lim_next = pos_reg[idx];
                end
            end
            KIND_TARGET: begin
                if (ref_reg[idx]) begin
                    if (t_ext < win_lo) begin
                        command   = CMD_IN;
                        ltgt_next = item_reg.value;
                        ldir_next = DIR_IN;
                        lsw_next  = 1'b0;
                    end else if (t_ext > win_hi) begin
                        command   = CMD_OUT;
                        ltgt_next = item_reg.value;
                        ldir_next = DIR_OUT;
                        lsw_next  = 1'b0;
                    end
                end
            end
            KIND_IN_SW, KIND_OUT_SW: begin
                if (cdir_reg[idx] == DIR_IN) begin
                    ctgt_next = sw_tgt;
                    csw_next  = 1'b1;
                end else begin
                    ltgt_next = sw_tgt;
                    ldir_next = (item_reg.kind == KIND_IN_SW) ? DIR_IN : DIR_OUT;
                    lsw_next  = 1'b1;
                end
            end
            KIND_TICK: begin
                if (ref_reg[idx]) begin
                    // adopt latch on motor start, drop target on stop
                    if (item_reg.motor_on && !act_reg[idx]) begin
                        ctgt_next = ltgt_reg[idx];
                        cdir_next = ldir_reg[idx];
                        csw_next  = lsw_reg[idx];
                        act_next  = 1'b1;
                    end else if (!item_reg.motor_on && act_reg[idx]) begin
                        cdir_next = DIR_NONE;
                        csw_next  = 1'b0;
                        act_next  = 1'b0;
                    end
                    pos_next = item_reg.adc_sample - pz_reg[idx];
                    if (act_next) begin
                        if (cdir_next == DIR_IN) begin
                            dist_val = pos_next - ctgt_next;
                        end else if (cdir_next == DIR_OUT) begin
                            dist_val = ctgt_next - pos_next;
                        end
                        // passed a switch target
                        if (($signed(dist_val) <= 16'sd0) && csw_next) begin
                            dist_val = NO_DIST;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (in_range) begin
            res_next.command       = command;
            res_next.distance      = dist_val;
            res_next.position      = pos_next;
            res_next.is_referenced = ref_next;
            res_next.is_moving     = act_next;
        end else begin
            res_next.command       = CMD_STOP;
            res_next.distance      = NO_DIST;
            res_next.position      = 16'sd0;
            res_next.is_referenced = 1'b0;
            res_next.is_moving     = 1'b0;
        end
    end

    // item and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            res_reg <= res_next;
        end
    end

    // channel state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                pos_reg[i]  <= 16'd0;
                ref_reg[i]  <= 1'b0;
                act_reg[i]  <= 1'b0;
                ctgt_reg[i] <= 16'd0;
                cdir_reg[i] <= DIR_NONE;
                csw_reg[i]  <= 1'b0;
                ltgt_reg[i] <= 16'd0;
                ldir_reg[i] <= DIR_NONE;
                lsw_reg[i]  <= 1'b0;
                band_reg[i] <= 16'd0;
                lim_reg[i]  <= LIMIT_DEF;
                pz_reg[i]   <= 16'd0;
            end
        end else if (cmd.commit && in_range) begin
            pos_reg[idx]  <= pos_next;
            ref_reg[idx]  <= ref_next;
            act_reg[idx]  <= act_next;
            ctgt_reg[idx] <= ctgt_next;
            cdir_reg[idx] <= cdir_next;
            csw_reg[idx]  <= csw_next;
            ltgt_reg[idx] <= ltgt_next;
            ldir_reg[idx] <= ldir_next;
            lsw_reg[idx]  <= lsw_next;
            band_reg[idx] <= band_next;
            lim_reg[idx]  <= lim_next;
            pz_reg[idx]   <= pz_next;
        end
    end

    assign m_data = res_reg;

endmodule

@@ rtl/actuator_position_targeting.sv @@
// flow: an accepted item is held in the item register, then executed into the result register
// a new item is taken only once the current one is executed, set by the controller's accept then execute
// sequence; the execute step waits while an earlier result is not yet taken
// reset: synchronous, active low; every channel returns at once to zero state
// with the out limit at 32767, no clearing pass
// top level: joins the controller and the datapath; depends on apt_pkg
module actuator_position_targeting #(
    parameter int CHANNELS = apt_pkg::CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  apt_pkg::apt_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output apt_pkg::apt_out_t m_data
);
    import apt_pkg::*;

    apt_cmd_t cmd;

    // handshake controller
    apt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // tracking datapath
    apt_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

@@ test/actuator_position_targeting_test.sv @@
// self-checking bench for actuator_position_targeting: random and directed event items,
// a per-channel tracking model of its own, random idling on both channels
// depends on apt_pkg and the actuator_position_targeting rtl
module actuator_position_targeting_test;
    import apt_pkg::*;

    localparam int CHANNELS = CHANNELS_DEF;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int ITEM_GOAL = 1900;
    localparam int QUIET_TAIL = 150;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        apt_in_t item;
        bit      drain_first;
    } queued_event_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    apt_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    apt_out_t m_data;

    actuator_position_targeting #(.CHANNELS(CHANNELS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // tracking model state, one entry per channel
    logic [15:0] chan_pos     [CHANNELS];
    logic        chan_ref     [CHANNELS];
    logic        chan_active  [CHANNELS];
    logic [15:0] run_target   [CHANNELS];
    logic [1:0]  run_dir      [CHANNELS];
    logic        run_switch   [CHANNELS];
    logic [15:0] armed_target [CHANNELS];
    logic [1:0]  armed_dir    [CHANNELS];
    logic        armed_switch [CHANNELS];
    logic [15:0] chan_band    [CHANNELS];
    logic [15:0] chan_limit   [CHANNELS];
    logic [15:0] chan_zero    [CHANNELS];

    queued_event_t pending_items[$];
    apt_out_t      expected_results[$];

    int  sent_n = 0;
    int  done_n = 0;
    int  error_n = 0;
    int  dist_reports = 0;
    int  cycle_n = 0;
    bit  quiet_tail = 1'b0;

    // sender and receiver idling
    int  send_gap = 0;
    int  send_calm = 0;
    int  stall_left = 0;
    int  recv_calm = 0;

    // stimulus planning state
    int          gen_pos  [16];
    logic [15:0] gen_zero [16];
    bit          gen_ref  [16];
    int          useful_n = 0;
    bit          drain_pending = 1'b0;

    // works out the result of one event item and advances the channel state
    function automatic apt_out_t track_event(apt_in_t ev);
        apt_out_t    r;
        int          c;
        int          t;
        int          p;
        int          b;
        logic [15:0] d;
        logic [15:0] sw_tgt;
        r.command = CMD_STOP;
        r.distance = NO_DIST;
        r.position = '0;
        r.is_referenced = 1'b0;
        r.is_moving = 1'b0;
        if (ev.channel >= CHANNELS)
            return r;
        c = int'(ev.channel);
        d = NO_DIST;
        case (ev.kind)
            KIND_INIT: begin
                chan_band[c] = ev.value;
                run_target[c] = '0;
                run_dir[c] = DIR_NONE;
                run_switch[c] = 1'b0;
                chan_active[c] = 1'b0;
                chan_ref[c] = 1'b0;
            end
            KIND_REF: begin
                chan_pos[c] = '0;
                chan_zero[c] = ev.adc_sample;
                chan_ref[c] = 1'b1;
            end
            KIND_LIMIT: begin
                if (chan_ref[c])
                    chan_limit[c] = chan_pos[c];
            end
            KIND_TARGET: begin
                // deadband window compared at full width, no wrap
                if (chan_ref[c]) begin
                    t = int'(ev.value);
                    p = int'($signed(chan_pos[c]));
                    b = int'($signed(chan_band[c]));
                    if (t < p - b) begin
                        r.command = CMD_IN;
                        armed_target[c] = ev.value;
                        armed_dir[c] = DIR_IN;
                        armed_switch[c] = 1'b0;
                    end else if (t > p + b) begin
                        r.command = CMD_OUT;
                        armed_target[c] = ev.value;
                        armed_dir[c] = DIR_OUT;
                        armed_switch[c] = 1'b0;
                    end
                end
            end
            KIND_IN_SW, KIND_OUT_SW: begin
                // an inward move is retargeted, otherwise the latch is loaded
                sw_tgt = (ev.kind == KIND_IN_SW) ? 16'd0 : chan_limit[c];
                if (run_dir[c] == DIR_IN) begin
                    run_target[c] = sw_tgt;
                    run_switch[c] = 1'b1;
                end else begin
                    armed_target[c] = sw_tgt;
                    armed_dir[c] = (ev.kind == KIND_IN_SW) ? DIR_IN : DIR_OUT;
                    armed_switch[c] = 1'b1;
                end
            end
            KIND_TICK: begin
                if (chan_ref[c]) begin
                    if (ev.motor_on && !chan_active[c]) begin
                        run_target[c] = armed_target[c];
                        run_dir[c] = armed_dir[c];
                        run_switch[c] = armed_switch[c];
                        chan_active[c] = 1'b1;
                    end else if (!ev.motor_on && chan_active[c]) begin
                        run_dir[c] = DIR_NONE;
                        run_switch[c] = 1'b0;
                        chan_active[c] = 1'b0;
                    end
                    chan_pos[c] = ev.adc_sample - chan_zero[c];
                    if (chan_active[c]) begin
                        if (run_dir[c] == DIR_IN)
                            d = chan_pos[c] - run_target[c];
                        else if (run_dir[c] == DIR_OUT)
                            d = run_target[c] - chan_pos[c];
                        // a switch target already passed reads as no target
                        if ($signed(d) <= 0 && run_switch[c])
                            d = NO_DIST;
                    end
                end
            end
            default: begin
            end
        endcase
        r.distance = d;
        r.position = chan_pos[c];
        r.is_referenced = chan_ref[c];
        r.is_moving = chan_active[c];
        return r;
    endfunction

    task automatic report_mismatch(string fld, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
        error_n++;
    endtask

    task automatic add_item(logic [2:0] kind, logic [3:0] ch, logic [15:0] value,
                            logic [15:0] adc, logic motor);
        queued_event_t q;
        q.item.kind = kind;
        q.item.channel = ch;
        q.item.value = value;
        q.item.adc_sample = adc;
        q.item.motor_on = motor;
        q.drain_first = drain_pending;
        drain_pending = 1'b0;
        pending_items.push_back(q);
        if (ch < CHANNELS)
            useful_n++;
    endtask

    task automatic add_switch(int ch);
        add_item($urandom_range(0, 1) ? KIND_IN_SW : KIND_OUT_SW, 4'(ch), 16'($urandom),
                 16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // one well-formed move: optional re-init and reference, target, run, stop
    task automatic plan_move(int ch);
        int              p;
        int              tgt;
        int              steps;
        int              j;
        logic [15:0]     zero;
        logic signed [15:0] rv;
        if (!gen_ref[ch] || $urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 2) == 0)
                add_item(KIND_INIT, 4'(ch),
                         16'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 400)),
                         16'($urandom), 1'($urandom_range(0, 1)));
            zero = 16'($urandom);
            add_item(KIND_REF, 4'(ch), 16'($urandom), zero, 1'($urandom_range(0, 1)));
            gen_zero[ch] = zero;
            gen_pos[ch] = 0;
            gen_ref[ch] = 1'b1;
        end
        p = gen_pos[ch];
        zero = gen_zero[ch];
        repeat ($urandom_range(0, 2)) begin
            j = $urandom_range(0, 8);
            add_item(KIND_TICK, 4'(ch), 16'($urandom), 16'(zero + p + j - 4), 1'b0);
        end
        if ($urandom_range(0, 5) == 0)
            add_item(KIND_LIMIT, 4'(ch), 16'($urandom), 16'($urandom),
                     1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0) begin
            rv = 16'($urandom);
            tgt = int'(rv);
        end else begin
            j = $urandom_range(0, 6000);
            tgt = p + j - 3000;
        end
        add_item(KIND_TARGET, 4'(ch), 16'(tgt), 16'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 4) == 0)
            add_switch(ch);
        steps = $urandom_range(2, 8);
        for (int k = 0; k < steps; k++) begin
            j = $urandom_range(0, 20);
            p = p + (tgt - p) / (steps - k) + j - 10;
            add_item(KIND_TICK, 4'(ch), 16'($urandom), 16'(zero + p), 1'b1);
            if ($urandom_range(0, 9) == 0)
                add_switch(ch);
        end
        repeat ($urandom_range(1, 2))
            add_item(KIND_TICK, 4'(ch), 16'($urandom), 16'(zero + p), 1'b0);
        gen_pos[ch] = p;
    endtask

    // clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time, sent_n - done_n);
            $display("actuator_position_targeting verification failed");
            $finish;
        end
    end

    // driver: presents pending items and predicts each accepted one
    always @(posedge aclk) begin
        apt_in_t nxt_data;
        logic    nxt_valid;
        logic    taken;
        if (!aresetn) begin
            s_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                chan_pos[c] = '0;
                chan_ref[c] = 1'b0;
                chan_active[c] = 1'b0;
                run_target[c] = '0;
                run_dir[c] = DIR_NONE;
                run_switch[c] = 1'b0;
                armed_target[c] = '0;
                armed_dir[c] = DIR_NONE;
                armed_switch[c] = 1'b0;
                chan_band[c] = '0;
                chan_limit[c] = LIMIT_DEF;
                chan_zero[c] = '0;
            end
        end else begin
            nxt_valid = s_valid;
            nxt_data = s_data;
            taken = s_valid && s_ready;
            if (taken) begin
                expected_results.push_back(track_event(s_data));
                sent_n <= sent_n + 1;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    if (pending_items[0].drain_first && (taken || sent_n != done_n)) begin
                        // hold off until every result is back
                    end else if (!quiet_tail && send_calm == 0
                                 && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 14) - 1;
                    end else begin
                        nxt_data = pending_items[0].item;
                        pending_items.pop_front();
                        nxt_valid = 1'b1;
                        if (send_calm > 0)
                            send_calm--;
                        else if ($urandom_range(0, 39) == 0)
                            send_calm = $urandom_range(40, 120);
                    end
                end
            end
            quiet_tail <= (pending_items.size() < QUIET_TAIL);
            s_valid <= nxt_valid;
            s_data <= nxt_data;
        end
    end

    // monitor: checks each result item against the oldest prediction
    always @(posedge aclk) begin
        apt_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with none expected, actual %h", $time, m_data);
                    error_n++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.distance != NO_DIST)
                        dist_reports++;
                    if (m_data.command !== want.command)
                        report_mismatch("command", 16'(want.command), 16'(m_data.command));
                    if (m_data.distance !== want.distance)
                        report_mismatch("distance", want.distance, m_data.distance);
                    if (m_data.position !== want.position)
                        report_mismatch("position", want.position, m_data.position);
                    if (m_data.is_referenced !== want.is_referenced)
                        report_mismatch("is_referenced", 16'(want.is_referenced),
                                        16'(m_data.is_referenced));
                    if (m_data.is_moving !== want.is_moving)
                        report_mismatch("is_moving", 16'(want.is_moving),
                                        16'(m_data.is_moving));
                end
                done_n <= done_n + 1;
            end
            // receiver stalls
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && recv_calm == 0 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 39) == 0)
                    recv_calm = $urandom_range(40, 120);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        for (int c = 0; c < 16; c++) begin
            gen_pos[c] = 0;
            gen_zero[c] = '0;
            gen_ref[c] = 1'b0;
        end

        // channels out of range and the unused kind
        add_item(KIND_TICK, 4'd15, 16'h7FFF, 16'hFFFF, 1'b1);
        add_item(KIND_INIT, 4'd8, 16'h8000, 16'h0000, 1'b0);
        add_item(KIND_UNUSED, 4'd0, 16'h1234, 16'h5678, 1'b1);
        // events on a channel never referenced
        add_item(KIND_TICK, 4'd0, 16'h0000, 16'h1234, 1'b1);
        add_item(KIND_TARGET, 4'd0, 16'd100, 16'h0000, 1'b0);
        add_item(KIND_LIMIT, 4'd0, 16'h0000, 16'h0000, 1'b0);
        // zero deadband, reference at full scale, target inside and at the negative extreme
        add_item(KIND_INIT, 4'd0, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_REF, 4'd0, 16'h0000, 16'hFFFF, 1'b0);
        add_item(KIND_TARGET, 4'd0, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TARGET, 4'd0, 16'h8000, 16'h0000, 1'b0);
        // inward move with wrapped position, retargeted to both switches
        add_item(KIND_TICK, 4'd0, 16'h0000, 16'h0010, 1'b1);
        add_item(KIND_IN_SW, 4'd0, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TICK, 4'd0, 16'h0000, 16'hFFFF, 1'b1);
        add_item(KIND_OUT_SW, 4'd0, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TICK, 4'd0, 16'h0000, 16'hFFFF, 1'b0);
        // out limit at zero, then an outward switch move already past its target
        add_item(KIND_LIMIT, 4'd0, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TARGET, 4'd0, 16'h7FFF, 16'h0000, 1'b0);
        add_item(KIND_OUT_SW, 4'd0, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TICK, 4'd0, 16'h0000, 16'h0005, 1'b1);
        // widest deadband, then a negative one
        add_item(KIND_INIT, 4'd7, 16'h7FFF, 16'h0000, 1'b0);
        add_item(KIND_REF, 4'd7, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TARGET, 4'd7, 16'h8000, 16'h0000, 1'b0);
        add_item(KIND_TARGET, 4'd7, 16'h7FFF, 16'h0000, 1'b0);
        add_item(KIND_INIT, 4'd7, 16'h8000, 16'h0000, 1'b0);
        add_item(KIND_TARGET, 4'd7, 16'h0000, 16'h0000, 1'b0);
        add_item(KIND_TICK, 4'd7, 16'h0000, 16'h8000, 1'b1);

        // random part: mostly well-formed moves, some raw noise
        while (useful_n < ITEM_GOAL) begin
            if (useful_n >= 600 && useful_n < 630)
                drain_pending = 1'b1;
            if (useful_n >= 1300 && useful_n < 1330)
                drain_pending = 1'b1;
            if ($urandom_range(0, 9) < 7)
                plan_move($urandom_range(0, CHANNELS - 1));
            else
                add_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                         16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || sent_n != done_n)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            error_n++;
        end

        $display("%0d event items over %0d channels, %0d results checked, %0d with a distance",
                 sent_n, CHANNELS, done_n, dist_reports);
        $display("%0d mismatches", error_n);
        if (error_n == 0)
            $display("actuator_position_targeting verification clean");
        else
            $display("actuator_position_targeting verification failed");
        $finish;
    end

endmodule

@@ actuator_position_targeting.f @@
+incdir+rtl
rtl/apt_pkg.sv
rtl/apt_ctrl.sv
rtl/apt_dp.sv
rtl/actuator_position_targeting.sv
test/actuator_position_targeting_test.sv
